FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/bat_pkg.sv
// Package for the buddy allocator: types, constants and controller commands.
`timescale 1ns / 1ps
package bat_pkg;
    localparam int POOL_BYTES      = 1048576;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int LEAVES          = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int NODE_COUNT      = 2 * LEAVES - 1;
    localparam int LEVELS          = $clog2(LEAVES) + 1;
    localparam int NODE_W          = $clog2(NODE_COUNT + 1);
    localparam int IDX_W           = $clog2(NODE_COUNT);
    localparam int LVL_W           = $clog2(LEVELS);
    localparam int SIZE_W          = $clog2(POOL_BYTES) + 1;
    localparam int OFF_W           = 20;
    localparam int REQ_W           = 21;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_SPLIT = 2'd1,
        ST_USED  = 2'd2,
        ST_RSVD  = 2'd3
    } t_node_st;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ROUND,
        S_A_RD, S_A_WAIT, S_A_EVAL, S_A_UP_RD, S_A_UP_WAIT, S_A_UP_EVAL,
        S_F_RD, S_F_WAIT, S_F_EVAL, S_M_RDL, S_M_RDR, S_M_WAIT, S_M_EVAL,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        C_NONE, C_CLEAR, C_LOAD, C_ROUND, C_RD, C_MARK, C_SPLIT_DOWN,
        C_DESCEND, C_UP, C_UP_WRITE_FREE, C_FREE_HIT, C_F_DOWN,
        C_RD_LEFT, C_RD_RIGHT, C_MERGE, C_SET_FAIL
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic     clear_done;
        logic     is_free_cmd;
        logic     req_ok;
        logic     round_done;
        t_node_st st;
        logic     in_tree;
        logic     size_lt_req;
        logic     size_eq_req;
        logic     size_is_min;
        logic     fresh;
        logic     is_right;
        logic     at_root;
        logic     tgt_upper;
        logic     off_match;
        t_node_st st_l;
        t_node_st st_r;
    } t_stat;
endpackage

FILE: design/bat_ctrl.sv
// Controller state machine for the buddy allocator walk.
`timescale 1ns / 1ps
module bat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_res_load,
    input  logic             i_res_free,
    input  bat_pkg::t_stat   i_stat,
    output bat_pkg::t_ctl    o_ctl
);
    bat_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bat_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl.cmd   = bat_pkg::C_NONE;
        o_req_ready = 1'b0;
        o_res_load  = 1'b0;
        unique case (r_state)
            bat_pkg::S_CLEAR: begin
                o_ctl.cmd = bat_pkg::C_CLEAR;
                if (i_stat.clear_done) begin
                    n_state = bat_pkg::S_IDLE;
                end
            end
            bat_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.cmd = bat_pkg::C_LOAD;
                    n_state   = bat_pkg::S_ROUND;
                end
            end
            bat_pkg::S_ROUND: begin
                o_ctl.cmd = bat_pkg::C_ROUND;
                if (i_stat.is_free_cmd) begin
                    n_state = bat_pkg::S_F_RD;
                end else if (!i_stat.req_ok) begin
                    n_state = bat_pkg::S_DONE;
                end else if (i_stat.round_done) begin
                    n_state = bat_pkg::S_A_RD;
                end
            end
            bat_pkg::S_A_RD: begin
                o_ctl.cmd = bat_pkg::C_RD;
                n_state   = bat_pkg::S_A_WAIT;
            end
            bat_pkg::S_A_WAIT: n_state = bat_pkg::S_A_EVAL;
            bat_pkg::S_A_EVAL: begin
                if (!i_stat.in_tree || i_stat.st == bat_pkg::ST_USED
                    || i_stat.size_lt_req
                    || (i_stat.st == bat_pkg::ST_FREE && !i_stat.size_eq_req
                        && i_stat.size_is_min)) begin
                    o_ctl.cmd = bat_pkg::C_UP;
                    n_state   = bat_pkg::S_A_UP_RD;
                end else if (i_stat.size_eq_req && i_stat.st == bat_pkg::ST_FREE) begin
                    o_ctl.cmd = bat_pkg::C_MARK;
                    n_state   = bat_pkg::S_DONE;
                end else if (i_stat.st == bat_pkg::ST_FREE) begin
                    o_ctl.cmd = bat_pkg::C_SPLIT_DOWN;
                    n_state   = bat_pkg::S_A_RD;
                end else begin
                    o_ctl.cmd = bat_pkg::C_DESCEND;
                    n_state   = bat_pkg::S_A_RD;
                end
            end
            // Backtrack: a failed root ends the request; otherwise step from the failed
            // child to its sibling or retire the parent (undoing a fresh split).
            bat_pkg::S_A_UP_RD: begin
                if (i_stat.at_root) begin
                    o_ctl.cmd = bat_pkg::C_SET_FAIL;
                    n_state   = bat_pkg::S_DONE;
                end else begin
                    n_state = bat_pkg::S_A_UP_WAIT;
                end
            end
            bat_pkg::S_A_UP_WAIT: n_state = bat_pkg::S_A_UP_EVAL;
            bat_pkg::S_A_UP_EVAL: begin
                o_ctl.cmd = bat_pkg::C_UP_WRITE_FREE;
                if (i_stat.is_right) begin
                    n_state = bat_pkg::S_A_UP_RD;
                end else begin
                    n_state = bat_pkg::S_A_RD;
                end
            end
            bat_pkg::S_F_RD: begin
                o_ctl.cmd = bat_pkg::C_RD;
                n_state   = bat_pkg::S_F_WAIT;
            end
            bat_pkg::S_F_WAIT: n_state = bat_pkg::S_F_EVAL;
            bat_pkg::S_F_EVAL: begin
                if (!i_stat.in_tree || i_stat.st == bat_pkg::ST_FREE) begin
                    o_ctl.cmd = bat_pkg::C_UP;
                    n_state   = bat_pkg::S_M_RDL;
                end else if (i_stat.st == bat_pkg::ST_USED) begin
                    o_ctl.cmd = bat_pkg::C_FREE_HIT;
                    n_state   = bat_pkg::S_M_RDL;
                end else begin
                    o_ctl.cmd = bat_pkg::C_F_DOWN;
                    n_state   = bat_pkg::S_F_RD;
                end
            end
            bat_pkg::S_M_RDL: begin
                if (i_stat.at_root) begin
                    n_state = bat_pkg::S_DONE;
                end else begin
                    o_ctl.cmd = bat_pkg::C_RD_LEFT;
                    n_state   = bat_pkg::S_M_RDR;
                end
            end
            bat_pkg::S_M_RDR: begin
                o_ctl.cmd = bat_pkg::C_RD_RIGHT;
                n_state   = bat_pkg::S_M_WAIT;
            end
            bat_pkg::S_M_WAIT: n_state = bat_pkg::S_M_EVAL;
            bat_pkg::S_M_EVAL: begin
                o_ctl.cmd = bat_pkg::C_MERGE;
                n_state   = bat_pkg::S_M_RDL;
            end
            bat_pkg::S_DONE: begin
                if (i_stat.is_free_cmd) begin
                    n_state = bat_pkg::S_IDLE;
                end else if (i_res_free) begin
                    o_res_load = 1'b1;
                    n_state    = bat_pkg::S_IDLE;
                end
            end
            default: n_state = bat_pkg::S_IDLE;
        endcase
    end
endmodule

FILE: design/bat_dpath.sv
// Datapath: node memory, walk registers and result register.
`timescale 1ns / 1ps
module bat_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bat_pkg::t_ctl              i_ctl,
    input  logic                       i_command,
    input  logic [bat_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [bat_pkg::OFF_W-1:0]  i_release_offset,
    input  logic                       i_res_load,
    output bat_pkg::t_stat             o_stat,
    output logic                       o_granted,
    output logic [bat_pkg::OFF_W-1:0]  o_block_offset
);
    // Node status memory: one write and one read per cycle, with write-to-read bypass.
    logic [1:0] r_mem [bat_pkg::NODE_COUNT];
    logic [1:0] r_rd;
    logic       r_we;
    logic [bat_pkg::IDX_W-1:0] r_waddr;
    logic [1:0]                r_wdata;

    logic [bat_pkg::NODE_W-1:0] r_node;
    logic [bat_pkg::SIZE_W-1:0] r_size;
    logic [bat_pkg::SIZE_W-1:0] r_req;
    logic [bat_pkg::OFF_W-1:0]  r_off;
    logic [bat_pkg::OFF_W-1:0]  r_tgt;
    logic [bat_pkg::REQ_W-1:0]  r_bytes;
    logic                       r_cmd;
    logic [bat_pkg::LEVELS-1:0] r_fresh;
    logic [bat_pkg::LVL_W-1:0]  r_lvl;
    logic [bat_pkg::IDX_W-1:0]  r_clr;
    logic                       r_clr_done;
    logic                       r_ok;
    logic [bat_pkg::OFF_W-1:0]  r_found;
    logic [1:0]                 r_st_l;
    logic [1:0]                 r_rd_q;

    logic [bat_pkg::NODE_W-1:0] w_parent;
    logic [bat_pkg::SIZE_W-1:0] w_half;
    logic [bat_pkg::OFF_W-1:0]  w_half_off;
    logic [bat_pkg::OFF_W-1:0]  w_size_off;
    logic                       w_rd_en;
    logic [bat_pkg::IDX_W-1:0]  w_rd_addr;
    logic [bat_pkg::NODE_W-1:0] w_left;

    function automatic logic [bat_pkg::REQ_W-1:0] SIZE_W_ext(
        input logic [bat_pkg::SIZE_W-1:0] v);
        return bat_pkg::REQ_W'(v);
    endfunction

    assign w_parent   = (r_node - 1'b1) >> 1;
    assign w_half     = r_size >> 1;
    assign w_half_off = w_half[bat_pkg::OFF_W-1:0];
    assign w_size_off = r_size[bat_pkg::OFF_W-1:0];
    assign w_left     = {w_parent[bat_pkg::NODE_W-2:0], 1'b1};

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_node[bat_pkg::IDX_W-1:0];
        unique case (i_ctl.cmd)
            bat_pkg::C_RD:       w_rd_en = 1'b1;
            bat_pkg::C_RD_LEFT:  begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_left[bat_pkg::IDX_W-1:0];
            end
            bat_pkg::C_RD_RIGHT: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_left[bat_pkg::IDX_W-1:0] + 1'b1;
            end
            default: ;
        endcase
    end

    // A read of the entry being written this cycle takes the new value.
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end
        if (w_rd_en) begin
            if (r_we && r_waddr == w_rd_addr) begin
                r_rd <= r_wdata;
            end else begin
                r_rd <= r_mem[w_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we       <= 1'b0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_fresh    <= '0;
            r_lvl      <= '0;
            r_node     <= '0;
            r_ok       <= 1'b0;
        end else begin
            r_we <= 1'b0;
            r_rd_q <= r_rd;
            unique case (i_ctl.cmd)
                bat_pkg::C_CLEAR: begin
                    if (!r_clr_done) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_clr;
                        r_wdata <= bat_pkg::ST_FREE;
                        r_clr   <= r_clr + 1'b1;
                        if (r_clr == bat_pkg::IDX_W'(bat_pkg::NODE_COUNT - 1)) begin
                            r_clr_done <= 1'b1;
                        end
                    end
                end
                bat_pkg::C_LOAD: begin
                    r_cmd   <= i_command;
                    r_bytes <= i_request_bytes;
                    r_tgt   <= i_release_offset;
                    r_req   <= bat_pkg::SIZE_W'(bat_pkg::MIN_BLOCK_BYTES);
                    r_node  <= '0;
                    r_size  <= bat_pkg::SIZE_W'(bat_pkg::POOL_BYTES);
                    r_off   <= '0;
                    r_lvl   <= '0;
                    r_fresh <= '0;
                    r_ok    <= 1'b0;
                    r_found <= '0;
                end
                bat_pkg::C_ROUND: begin
                    if (SIZE_W_ext(r_req) < r_bytes) begin
                        r_req <= r_req << 1;
                    end
                end
                bat_pkg::C_MARK: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_node[bat_pkg::IDX_W-1:0];
                    r_wdata <= bat_pkg::ST_USED;
                    r_ok    <= 1'b1;
                    r_found <= r_off;
                end
                bat_pkg::C_SPLIT_DOWN, bat_pkg::C_DESCEND: begin
                    if (i_ctl.cmd == bat_pkg::C_SPLIT_DOWN) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_node[bat_pkg::IDX_W-1:0];
                        r_wdata <= bat_pkg::ST_SPLIT;
                    end
                    r_fresh[r_lvl] <= (i_ctl.cmd == bat_pkg::C_SPLIT_DOWN);
                    r_node <= {r_node[bat_pkg::NODE_W-2:0], 1'b1};
                    r_size <= w_half;
                    r_lvl  <= r_lvl + 1'b1;
                end
                bat_pkg::C_UP: ;
                bat_pkg::C_UP_WRITE_FREE: begin
                    // r_node still names the failed child; r_lvl its depth.
                    if (!r_node[0]) begin
                        // Right child failed: retire to parent, undo fresh split.
                        if (r_fresh[r_lvl - 1'b1]) begin
                            r_we    <= 1'b1;
                            r_waddr <= w_parent[bat_pkg::IDX_W-1:0];
                            r_wdata <= bat_pkg::ST_FREE;
                        end
                        r_node <= w_parent;
                        r_size <= r_size << 1;
                        r_off  <= r_off - w_size_off;
                        r_lvl  <= r_lvl - 1'b1;
                    end else begin
                        r_node <= r_node + 1'b1;
                        r_off  <= r_off + w_size_off;
                    end
                end
                bat_pkg::C_FREE_HIT: begin
                    if (r_off == r_tgt) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_node[bat_pkg::IDX_W-1:0];
                        r_wdata <= bat_pkg::ST_FREE;
                    end
                end
                bat_pkg::C_F_DOWN: begin
                    if (r_tgt < r_off + w_half_off) begin
                        r_node <= {r_node[bat_pkg::NODE_W-2:0], 1'b1};
                    end else begin
                        r_node <= {r_node[bat_pkg::NODE_W-2:0], 1'b0} + 2'd2;
                        r_off  <= r_off + w_half_off;
                    end
                    r_size <= w_half;
                end
                bat_pkg::C_RD_LEFT: ;
                bat_pkg::C_RD_RIGHT: r_st_l <= r_rd;
                bat_pkg::C_MERGE: begin
                    // Parent is split (we came down through it); merge if both free.
                    if (r_st_l == bat_pkg::ST_FREE && r_rd == bat_pkg::ST_FREE) begin
                        r_we    <= 1'b1;
                        r_waddr <= w_parent[bat_pkg::IDX_W-1:0];
                        r_wdata <= bat_pkg::ST_FREE;
                    end
                    r_node <= w_parent;
                    r_size <= r_size << 1;
                end
                bat_pkg::C_SET_FAIL: r_ok <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_load) begin
            o_granted      <= r_ok;
            o_block_offset <= r_ok ? r_found : '0;
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.clear_done  = r_clr_done;
        o_stat.is_free_cmd = r_cmd;
        o_stat.req_ok      = (r_bytes != '0)
                           && (r_bytes <= bat_pkg::REQ_W'(bat_pkg::POOL_BYTES));
        o_stat.round_done  = !(SIZE_W_ext(r_req) < r_bytes);
        o_stat.st          = bat_pkg::t_node_st'(r_rd);
        o_stat.in_tree     = r_node < bat_pkg::NODE_W'(bat_pkg::NODE_COUNT);
        o_stat.size_lt_req = r_size < r_req;
        o_stat.size_eq_req = r_size == r_req;
        o_stat.size_is_min = r_size <= bat_pkg::SIZE_W'(bat_pkg::MIN_BLOCK_BYTES);
        o_stat.fresh       = r_fresh[r_lvl];
        o_stat.is_right    = !r_node[0];
        o_stat.at_root     = r_node == '0;
        o_stat.tgt_upper   = r_tgt >= r_off + w_half_off;
        o_stat.off_match   = r_off == r_tgt;
        o_stat.st_l        = bat_pkg::t_node_st'(r_st_l);
        o_stat.st_r        = bat_pkg::t_node_st'(r_rd_q);
    end
endmodule

FILE: design/buddy_allocator_tree.sv
// Top level of the binary buddy allocator.
// Allocate: a refused size (zero or over the pool) is answered without a walk; else the size
// is rounded up to a power of two, then nodes are read and tested, failed ones backed out of.
// Free: walks down to the block, then checks for merges back up to the root; no result.
// Requests: one at a time, as a request is taken only while the node memory walk is idle.
// Reset: synchronous; a clearing pass marks every node free, no request taken until it ends.
`timescale 1ns / 1ps
module buddy_allocator_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [0] command, [21:1] request_bytes, [41:22] release_offset
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [0] granted, [20:1] block_offset
    output logic [23:0] m_axis_tdata
);
    bat_pkg::t_ctl  w_ctl;
    bat_pkg::t_stat w_stat;
    logic           w_res_load;
    logic           r_out_valid;
    logic           w_granted;
    logic [19:0]    w_off;

    // Result register is free once the downstream side has taken it.
    bat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_res_load  (w_res_load),
        .i_res_free  (!r_out_valid || m_axis_tready),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    bat_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_command        (s_axis_tdata[0]),
        .i_request_bytes  (s_axis_tdata[21:1]),
        .i_release_offset (s_axis_tdata[41:22]),
        .i_res_load       (w_res_load),
        .o_stat           (w_stat),
        .o_granted        (w_granted),
        .o_block_offset   (w_off)
    );

    // Hold the result until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, w_off, w_granted};
endmodule

FILE: design/bat_checker.sv
// Port checker for the buddy allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    `BA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[20:1] == 20'd0, "refused request carries nonzero offset")
    `BA_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while walk busy")
    `BA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `BA_ASSERT_IMP(a_grant_aligned, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[5:1] == 5'd0, "granted offset off block grid")
endmodule

bind buddy_allocator_tree bat_checker u_bat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
